// ===== src/supi_pkg.sv =====
`default_nettype none

package supi_pkg;

    // Default table size and field widths
    localparam int SUPI_TABLE_DEPTH = 512;
    localparam int SUPI_KEY_W       = 16;
    localparam int SUPI_IDX_W       = 10;
    localparam int SUPI_STATUS_W    = 2;

    // Result status codes
    localparam logic [SUPI_STATUS_W-1:0] ST_ADDED   = 2'd0;
    localparam logic [SUPI_STATUS_W-1:0] ST_PRESENT = 2'd1;
    localparam logic [SUPI_STATUS_W-1:0] ST_FULL    = 2'd2;

    // Input beat: one offered pair
    typedef struct packed {
        logic [SUPI_KEY_W-1:0] pair_width;
        logic [SUPI_KEY_W-1:0] pair_height;
    } t_pair_in;

    // Result beat
    typedef struct packed {
        logic [SUPI_STATUS_W-1:0] status;
        logic [SUPI_IDX_W-1:0]    position;
        logic [SUPI_IDX_W-1:0]    entry_count;
    } t_pair_out;

    // Commands from controller to datapath
    typedef struct packed {
        logic                     load_key;
        logic                     idx_clr;
        logic                     idx_inc;
        logic                     pos_load;
        logic                     j_load;
        logic                     j_dec;
        logic                     rd_en;
        logic                     rd_shift;
        logic                     wr_shift;
        logic                     wr_key;
        logic                     count_inc;
        logic                     res_load;
        logic [SUPI_STATUS_W-1:0] res_status;
    } t_supi_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic idx_at_count;
        logic is_full;
        logic rd_eq;
        logic rd_gt;
        logic j_at_pos;
    } t_supi_stat;

endpackage

`default_nettype wire

// ===== src/sorted_unique_pair_insert_top.sv =====
`default_nettype none

// Sorted table of unique (width, height) pairs, ascending by width then height.
// Pulse start while busy is low to offer i_pair; busy rises on the next cycle and
// one result beat appears on o_result with o_valid high for a single cycle, which
// must be taken then since it cannot be held off. The table sits in one
// single-port memory with a registered read, so every entry touched passes a
// read state and then a compare or write state: the search walks up from entry
// 0 to the match or insertion point, and an insert then moves each larger entry
// up one place. The result beat appears in the same cycle that busy falls.
// The table starts empty after reset with no clearing pass; only entries below
// the count are ever read.
module sorted_unique_pair_insert_top #(
    parameter int TABLE_DEPTH = supi_pkg::SUPI_TABLE_DEPTH
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  supi_pkg::t_pair_in  i_pair,
    output logic                o_valid,
    output supi_pkg::t_pair_out o_result
);
    import supi_pkg::*;

    t_supi_cmd  cmd;
    t_supi_stat stat;

    // Sequence the search, shift and insert
    supi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    // Table memory, indexes and result register
    supi_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pair   (i_pair),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

// ===== src/supi_datapath.sv =====
`default_nettype none

module supi_datapath #(
    parameter int TABLE_DEPTH = supi_pkg::SUPI_TABLE_DEPTH
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  supi_pkg::t_pair_in   i_pair,
    input  supi_pkg::t_supi_cmd  i_cmd,
    output supi_pkg::t_supi_stat o_stat,
    output supi_pkg::t_pair_out  o_result
);
    import supi_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int DW = 2 * SUPI_KEY_W;

    logic [DW-1:0] r_mem [TABLE_DEPTH];
    logic [DW-1:0] r_key;
    logic [DW-1:0] r_rdata;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_pos;
    logic [CW-1:0] r_j;
    logic [CW-1:0] r_count;
    t_pair_out     r_result;

    logic [CW-1:0] j_m1;
    logic [CW-1:0] count_p1;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic          wr_en;

    // Address and data selection for the table port
    assign j_m1     = r_j - CW'(1);
    assign count_p1 = r_count + CW'(1);
    assign rd_addr  = i_cmd.rd_shift ? j_m1[AW-1:0] : r_idx[AW-1:0];
    assign wr_addr  = i_cmd.wr_shift ? r_j[AW-1:0] : r_pos[AW-1:0];
    assign wr_data  = i_cmd.wr_shift ? r_rdata : r_key;
    assign wr_en    = i_cmd.wr_shift | i_cmd.wr_key;

    // Table memory with registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Hold key and scan indexes
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_key) begin
            r_key <= {i_pair.pair_width, i_pair.pair_height};
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.pos_load) begin
            r_pos <= r_idx;
        end
        if (i_cmd.j_load) begin
            r_j <= r_count;
        end else if (i_cmd.j_dec) begin
            r_j <= j_m1;
        end
    end

    // Advance the entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.count_inc) begin
            r_count <= count_p1;
        end
    end

    // Capture the result beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_result.status <= i_cmd.res_status;
            case (i_cmd.res_status)
                ST_ADDED: begin
                    r_result.position    <= SUPI_IDX_W'(r_pos);
                    r_result.entry_count <= SUPI_IDX_W'(count_p1);
                end
                ST_PRESENT: begin
                    r_result.position    <= SUPI_IDX_W'(r_idx);
                    r_result.entry_count <= SUPI_IDX_W'(r_count);
                end
                default: begin
                    r_result.position    <= '0;
                    r_result.entry_count <= SUPI_IDX_W'(r_count);
                end
            endcase
        end
    end

    assign o_stat.idx_at_count = (r_idx == r_count);
    assign o_stat.is_full      = (r_count == CW'(TABLE_DEPTH));
    assign o_stat.rd_eq        = (r_rdata == r_key);
    assign o_stat.rd_gt        = (r_rdata > r_key);
    assign o_stat.j_at_pos     = (r_j == r_pos);
    assign o_result            = r_result;

endmodule

`default_nettype wire

// ===== src/supi_ctrl.sv =====
`default_nettype none

module supi_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  supi_pkg::t_supi_stat i_stat,
    output supi_pkg::t_supi_cmd  o_cmd,
    output logic                 o_busy,
    output logic                 o_valid
);
    import supi_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_SETUP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INSERT
    } t_state;

    t_state    r_state;
    t_state    n_state;
    logic      r_valid;
    t_supi_cmd cmd;

    // Decode commands and next state
    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load_key = 1'b1;
                    cmd.idx_clr  = 1'b1;
                    n_state      = S_SRCH_RD;
                end
            end
            S_SRCH_RD: begin
                if (i_stat.idx_at_count) begin
                    cmd.pos_load = 1'b1;
                    n_state      = S_SHIFT_SETUP;
                end else begin
                    cmd.rd_en = 1'b1;
                    n_state   = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                if (i_stat.rd_eq) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_PRESENT;
                    n_state        = S_IDLE;
                end else if (i_stat.rd_gt) begin
                    cmd.pos_load = 1'b1;
                    n_state      = S_SHIFT_SETUP;
                end else begin
                    cmd.idx_inc = 1'b1;
                    n_state     = S_SRCH_RD;
                end
            end
            S_SHIFT_SETUP: begin
                if (i_stat.is_full) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_FULL;
                    n_state        = S_IDLE;
                end else begin
                    cmd.j_load = 1'b1;
                    n_state    = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: begin
                if (i_stat.j_at_pos) begin
                    n_state = S_INSERT;
                end else begin
                    cmd.rd_en    = 1'b1;
                    cmd.rd_shift = 1'b1;
                    n_state      = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                cmd.wr_shift = 1'b1;
                cmd.j_dec    = 1'b1;
                n_state      = S_SHIFT_RD;
            end
            S_INSERT: begin
                cmd.wr_key     = 1'b1;
                cmd.count_inc  = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_ADDED;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and the result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= cmd.res_load;
        end
    end

    assign o_cmd   = cmd;
    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

`default_nettype wire

// ===== src/supi_checker.sv =====
`default_nettype none

module supi_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 start,
    input wire                 busy,
    input wire                 o_valid,
    input supi_pkg::t_pair_out o_result
);
    import supi_pkg::*;

    // A result beat closes the item, so the block is idle then
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while busy");

    // An accepted item keeps the block busy on the next cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accepted item did not raise busy");

    // A full table reports position zero
    a_full_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == ST_FULL) |-> (o_result.position == '0))
        else $error("full result with nonzero position");

    // Status codes stay within the defined set
    a_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.status == ST_ADDED || o_result.status == ST_PRESENT
                     || o_result.status == ST_FULL))
        else $error("undefined status code");

    // An added pair leaves at least one entry
    a_added_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == ST_ADDED) |->
            (o_result.entry_count != '0))
        else $error("added pair with empty count");

endmodule

bind sorted_unique_pair_insert_top supi_checker u_supi_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

`default_nettype wire
